// ----- rtl/prqs_pkg.sv -----
// Shared types, field widths and operation codes of the ready-queue scheduler.
package prqs_pkg;

  // Field widths of one input item and one result item.
  localparam int OPCODE_W     = 3;
  localparam int SLOT_FIELD_W = 3;
  localparam int PRIO_FIELD_W = 4;
  localparam int STATUS_W     = 2;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 16;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_CREATE   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUT      = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_GET      = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SCHEDULE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CHPRIO   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_RELEASE  = 3'd5;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;

  // Input item as packed in tdata, last field in the lowest bits.
  typedef struct packed {
    logic [PRIO_FIELD_W-1:0] prio_value;
    logic [SLOT_FIELD_W-1:0] thread_slot;
    logic [OPCODE_W-1:0]     opcode;
  } in_item_t;

  // Result item as packed in tdata, last field in the lowest bits.
  typedef struct packed {
    logic [PRIO_FIELD_W-1:0] old_prio;
    logic [SLOT_FIELD_W-1:0] chosen_slot;
    logic [STATUS_W-1:0]     status;
  } res_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic [OPCODE_W-1:0]     opcode;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    slot_ok;
    logic [PRIO_FIELD_W-1:0] prio_clamped;
    logic                    prio_given;
  } cmd_t;

endpackage

// ----- rtl/prqs_front.sv -----
// Front part: takes input items and classifies them into commands for the queue.
module prqs_front #(
  parameter int NUM_SLOTS  = 6,
  parameter int NUM_LEVELS = 16
) (
  input  logic               in_tvalid,
  output logic               in_tready,
  input  prqs_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               q_push,
  output prqs_pkg::cmd_t     q_cmd
);

  localparam int PF_W = prqs_pkg::PRIO_FIELD_W;

  // An item is taken whenever the queue has room.
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Range check of the slot and saturation of the priority.
  always_comb begin
    q_cmd.opcode     = in_item.opcode;
    q_cmd.slot       = in_item.thread_slot;
    q_cmd.slot_ok    = int'(in_item.thread_slot) < NUM_SLOTS;
    q_cmd.prio_given = in_item.prio_value != '0;
    if (int'(in_item.prio_value) >= NUM_LEVELS) begin
      q_cmd.prio_clamped = PF_W'(NUM_LEVELS - 1);
    end else begin
      q_cmd.prio_clamped = in_item.prio_value;
    end
  end

endmodule

// ----- rtl/prqs_queue.sv -----
// Short command queue that decouples the front part from the back part.
module prqs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  prqs_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           valid,
  input  logic           pop,
  output prqs_pkg::cmd_t cmd
);

  localparam int DEPTH = prqs_pkg::QUEUE_DEPTH;
  localparam int PW    = prqs_pkg::QPTR_W;

  prqs_pkg::cmd_t entries_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [PW:0]    count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = count_r == (PW+1)'(DEPTH);
  assign valid   = count_r != '0;
  assign cmd     = entries_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill-count update; pointers wrap at the depth.
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (int'(wptr_r) == DEPTH - 1) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (int'(rptr_r) == DEPTH - 1) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/prqs_back.sv -----
// Back part: sequencer that carries out queue commands on the slot and level tables.
module prqs_back #(
  parameter int NUM_SLOTS  = 6,
  parameter int NUM_LEVELS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  prqs_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output prqs_pkg::res_t out_res
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int SF_W   = prqs_pkg::SLOT_FIELD_W;
  localparam int PF_W   = prqs_pkg::PRIO_FIELD_W;
  localparam int OP_W   = prqs_pkg::OPCODE_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_ENQ_RD  = 4'd2;
  localparam logic [3:0] S_ENQ_WR  = 4'd3;
  localparam logic [3:0] S_UL_RD   = 4'd4;
  localparam logic [3:0] S_UL_LOAD = 4'd5;
  localparam logic [3:0] S_UL_WALK = 4'd6;
  localparam logic [3:0] S_UL_END  = 4'd7;
  localparam logic [3:0] S_SCHED   = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]            state_r, state_nxt;

  // Per-slot and per-level flag vectors, cleared at reset.
  logic [NUM_SLOTS-1:0]  used_r, used_nxt;
  logic [NUM_SLOTS-1:0]  ready_r, ready_nxt;
  logic [NUM_SLOTS-1:0]  lvalid_r, lvalid_nxt;
  logic [NUM_LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Working registers of the current command.
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  slot_ok_r, slot_ok_nxt;
  logic [PF_W-1:0]       prio_new_r, prio_new_nxt;
  logic                  prio_given_r, prio_given_nxt;
  logic [LVL_W-1:0]      lv_r, lv_nxt;
  logic [LVL_W-1:0]      newlv_r, newlv_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic [SLOT_W-1:0]     prev_r, prev_nxt;
  logic                  has_prev_r, has_prev_nxt;
  logic [SLOT_W-1:0]     snext_r, snext_nxt;
  prqs_pkg::res_t        res_r, res_nxt;
  prqs_pkg::res_t        out_res_r, out_res_nxt;

  // Table memories with registered read data.
  logic [SLOT_W-1:0]     head_mem [NUM_LEVELS];
  logic [SLOT_W-1:0]     tail_mem [NUM_LEVELS];
  logic [SLOT_W-1:0]     link_mem [NUM_SLOTS];
  logic [LVL_W-1:0]      prio_mem [NUM_SLOTS];

  logic                  head_we, tail_we, link_we, prio_we;
  logic [LVL_W-1:0]      head_wa, tail_wa, head_ra, tail_ra;
  logic [SLOT_W-1:0]     head_wd, tail_wd, link_wd, link_wa, link_ra;
  logic [SLOT_W-1:0]     prio_wa, prio_ra;
  logic [LVL_W-1:0]      prio_wd;
  logic [SLOT_W-1:0]     head_rd_r, tail_rd_r, link_rd_r;
  logic [LVL_W-1:0]      prio_rd_r;

  logic                  free_found, any_ready;
  logic [SLOT_W-1:0]     free_idx;
  logic [LVL_W-1:0]      first_lv;
  logic [LVL_W-1:0]      chg_prio;
  logic                  slot_live;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Lowest free slot and lowest non-empty level.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
    any_ready = 1'b0;
    first_lv  = '0;
    for (int j = NUM_LEVELS - 1; j >= 0; j--) begin
      if (nonempty_r[j]) begin
        any_ready = 1'b1;
        first_lv  = LVL_W'(j);
      end
    end
  end

  assign slot_live = slot_ok_r && used_r[slot_r];
  assign chg_prio  = prio_given_r ? LVL_W'(prio_new_r) : prio_rd_r;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    ready_nxt      = ready_r;
    lvalid_nxt     = lvalid_r;
    nonempty_nxt   = nonempty_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    slot_ok_nxt    = slot_ok_r;
    prio_new_nxt   = prio_new_r;
    prio_given_nxt = prio_given_r;
    lv_nxt         = lv_r;
    newlv_nxt      = newlv_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    has_prev_nxt   = has_prev_r;
    snext_nxt      = snext_r;
    res_nxt        = res_r;
    out_res_nxt    = out_res_r;
    q_pop          = 1'b0;
    head_we = 1'b0; head_wa = lv_r; head_wd = slot_r; head_ra = lv_r;
    tail_we = 1'b0; tail_wa = lv_r; tail_wd = slot_r; tail_ra = lv_r;
    link_we = 1'b0; link_wa = slot_r; link_wd = slot_r; link_ra = slot_r;
    prio_we = 1'b0; prio_wa = slot_r; prio_wd = lv_r; prio_ra = slot_r;

    case (state_r)
      // Take the next command and start the priority read of its slot.
      S_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          op_nxt         = q_cmd.opcode;
          slot_ok_nxt    = q_cmd.slot_ok;
          slot_nxt       = q_cmd.slot_ok ? SLOT_W'(q_cmd.slot) : '0;
          prio_new_nxt   = q_cmd.prio_clamped;
          prio_given_nxt = q_cmd.prio_given;
          prio_ra        = q_cmd.slot_ok ? SLOT_W'(q_cmd.slot) : '0;
          res_nxt        = '0;
          state_nxt      = S_DISP;
        end
      end

      // Decide what the command needs from the slot flags and its priority.
      S_DISP: begin
        state_nxt = S_DONE;
        case (op_r)
          prqs_pkg::OP_CREATE: begin
            if (free_found) begin
              slot_nxt            = free_idx;
              used_nxt[free_idx]  = 1'b1;
              prio_we             = 1'b1;
              prio_wa             = free_idx;
              prio_wd             = LVL_W'(prio_new_r);
              lv_nxt              = LVL_W'(prio_new_r);
              res_nxt.chosen_slot = SF_W'(free_idx);
              state_nxt           = S_ENQ_RD;
            end else begin
              res_nxt.status = prqs_pkg::ST_NONE;
            end
          end
          prqs_pkg::OP_SCHEDULE: begin
            if (any_ready) begin
              head_ra   = first_lv;
              state_nxt = S_SCHED;
            end else begin
              res_nxt.status = prqs_pkg::ST_NONE;
            end
          end
          prqs_pkg::OP_RELEASE: begin
            if (slot_live) begin
              if (ready_r[slot_r]) begin
                lv_nxt    = prio_rd_r;
                state_nxt = S_UL_RD;
              end else begin
                used_nxt[slot_r] = 1'b0;
              end
            end
          end
          prqs_pkg::OP_PUT: begin
            if (slot_live) begin
              if (ready_r[slot_r]) begin
                res_nxt.status = prqs_pkg::ST_ALREADY;
              end else begin
                lv_nxt    = prio_rd_r;
                state_nxt = S_ENQ_RD;
              end
            end
          end
          prqs_pkg::OP_GET: begin
            if (slot_live) begin
              if (!ready_r[slot_r]) begin
                res_nxt.status = prqs_pkg::ST_ALREADY;
              end else begin
                lv_nxt    = prio_rd_r;
                state_nxt = S_UL_RD;
              end
            end
          end
          prqs_pkg::OP_CHPRIO: begin
            if (slot_live) begin
              res_nxt.old_prio = PF_W'(prio_rd_r);
              if (ready_r[slot_r]) begin
                if (chg_prio == prio_rd_r) begin
                  res_nxt.status = prqs_pkg::ST_ALREADY;
                end else begin
                  lv_nxt    = prio_rd_r;
                  newlv_nxt = chg_prio;
                  state_nxt = S_UL_RD;
                end
              end else begin
                prio_we   = 1'b1;
                prio_wd   = chg_prio;
                lv_nxt    = chg_prio;
                state_nxt = S_ENQ_RD;
              end
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Enqueue at the tail: read the level's tail, then link the slot behind it.
      S_ENQ_RD: begin
        tail_ra   = lv_r;
        state_nxt = S_ENQ_WR;
      end

      S_ENQ_WR: begin
        if (nonempty_r[lv_r]) begin
          link_we               = 1'b1;
          link_wa               = tail_rd_r;
          link_wd               = slot_r;
          lvalid_nxt[tail_rd_r] = 1'b1;
        end else begin
          head_we              = 1'b1;
          head_wa              = lv_r;
          head_wd              = slot_r;
          nonempty_nxt[lv_r]   = 1'b1;
        end
        tail_we            = 1'b1;
        tail_wa            = lv_r;
        tail_wd            = slot_r;
        ready_nxt[slot_r]  = 1'b1;
        lvalid_nxt[slot_r] = 1'b0;
        state_nxt          = S_DONE;
      end

      // Unlink: read the level head and the slot's own successor together.
      S_UL_RD: begin
        if (nonempty_r[lv_r]) begin
          head_ra      = lv_r;
          link_ra      = slot_r;
          has_prev_nxt = 1'b0;
          state_nxt    = S_UL_LOAD;
        end else begin
          state_nxt = S_UL_END;
        end
      end

      S_UL_LOAD: begin
        cur_nxt = has_prev_r ? link_rd_r : head_rd_r;
        if (!has_prev_r) begin
          snext_nxt = link_rd_r;
        end
        state_nxt = S_UL_WALK;
      end

      // One list position per visit; splice the slot out once it is found.
      S_UL_WALK: begin
        if (cur_r == slot_r) begin
          if (!has_prev_r) begin
            if (lvalid_r[slot_r]) begin
              head_we = 1'b1;
              head_wa = lv_r;
              head_wd = snext_r;
            end else begin
              nonempty_nxt[lv_r] = 1'b0;
            end
          end else begin
            lvalid_nxt[prev_r] = lvalid_r[slot_r];
            link_we            = 1'b1;
            link_wa            = prev_r;
            link_wd            = snext_r;
            if (!lvalid_r[slot_r]) begin
              tail_we = 1'b1;
              tail_wa = lv_r;
              tail_wd = prev_r;
            end
          end
          state_nxt = S_UL_END;
        end else if (!lvalid_r[cur_r]) begin
          state_nxt = S_UL_END;
        end else begin
          prev_nxt     = cur_r;
          has_prev_nxt = 1'b1;
          link_ra      = cur_r;
          state_nxt    = S_UL_LOAD;
        end
      end

      // After unlinking: requeue at the new level, free the slot, or finish.
      S_UL_END: begin
        ready_nxt[slot_r]  = 1'b0;
        lvalid_nxt[slot_r] = 1'b0;
        state_nxt          = S_DONE;
        case (op_r)
          prqs_pkg::OP_CHPRIO: begin
            prio_we   = 1'b1;
            prio_wd   = newlv_r;
            lv_nxt    = newlv_r;
            state_nxt = S_ENQ_RD;
          end
          prqs_pkg::OP_RELEASE: begin
            used_nxt[slot_r] = 1'b0;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_SCHED: begin
        res_nxt.chosen_slot = SF_W'(head_rd_r);
        state_nxt           = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      ready_r     <= '0;
      lvalid_r    <= '0;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ready_r     <= ready_nxt;
      lvalid_r    <= lvalid_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    slot_ok_r    <= slot_ok_nxt;
    prio_new_r   <= prio_new_nxt;
    prio_given_r <= prio_given_nxt;
    lv_r         <= lv_nxt;
    newlv_r      <= newlv_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    has_prev_r   <= has_prev_nxt;
    snext_r      <= snext_nxt;
    res_r        <= res_nxt;
    out_res_r    <= out_res_nxt;
  end

  // Level head and tail memories.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail_mem[tail_wa] <= tail_wd;
    end
    tail_rd_r <= tail_mem[tail_ra];
  end

  // Per-slot successor link and priority memories.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_r <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (prio_we) begin
      prio_mem[prio_wa] <= prio_wd;
    end
    prio_rd_r <= prio_mem[prio_ra];
  end

endmodule

// ----- rtl/priority_ready_queue_scheduler.sv -----
// Top level of the multilevel priority ready-queue scheduler.
// Keeps one FIFO list of ready thread slots per priority level and answers one
// result item per input item (create, put, get, schedule, change priority,
// release). Items pass through a two-entry command queue into a sequencer that
// works on one item at a time, so the input side keeps accepting while a
// result waits on the output register, until the command queue is full.
// Create, put, schedule, a release of a non-ready slot and every error case
// need no list walk in the sequencer. Get, release of a ready slot and a
// priority change of a ready slot walk the level's linked list through the
// single link memory port, and a priority change then enqueues the slot at
// the new level. No clearing pass is needed after reset.
module priority_ready_queue_scheduler #(
  parameter int NUM_SLOTS  = 6,
  parameter int NUM_LEVELS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // opcode [2:0], thread_slot [5:3], prio_value [9:6]
  input  logic [prqs_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status [1:0], chosen_slot [4:2], old_prio [8:5]
  output logic [prqs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int RES_W = $bits(prqs_pkg::res_t);
  localparam int IN_W  = $bits(prqs_pkg::in_item_t);

  prqs_pkg::in_item_t in_item;
  prqs_pkg::cmd_t     push_cmd;
  prqs_pkg::cmd_t     q_cmd;
  prqs_pkg::res_t     out_res;
  logic               q_push, q_full, q_valid, q_pop;

  assign in_item   = prqs_pkg::in_item_t'(in_tdata[IN_W-1:0]);
  assign out_tdata = {{(prqs_pkg::OUT_TDATA_W - RES_W){1'b0}}, out_res};

  prqs_front #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  prqs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .cmd      (q_cmd)
  );

  prqs_back #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // A full command queue must hold off the input side.
  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_tready)
    else $error("input accepted while the command queue is full");

  // A popped command always leaves the queue non-empty beforehand.
  a_pop_only_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

  // Only create and schedule give a slot, only change priority gives an old priority.
  a_result_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.chosen_slot != '0 |-> out_res.old_prio == '0)
    else $error("result carries both a chosen slot and an old priority");

  // A failed create or an empty schedule reports nothing else.
  a_none_is_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.status == prqs_pkg::ST_NONE |->
      out_res.chosen_slot == '0 && out_res.old_prio == '0)
    else $error("no-slot or nothing-ready result with nonzero fields");

endmodule

// ----- tb/sv/priority_ready_queue_scheduler_check.sv -----
// Checker of the ready-queue scheduler: watches both item channels, predicts and compares results.
`timescale 1ns / 100ps

module priority_ready_queue_scheduler_check #(
  parameter int NUM_SLOTS  = 6,
  parameter int NUM_LEVELS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // opcode [2:0], thread_slot [5:3], prio_value [9:6]
  input  logic [prqs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // status [1:0], chosen_slot [4:2], old_prio [8:5]
  input  logic [prqs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                               errors,
  output int                               checked,
  output int                               outstanding
);
  import prqs_pkg::*;

  typedef logic [SLOT_FIELD_W-1:0] slot_t;
  typedef logic [PRIO_FIELD_W-1:0] prio_t;

  // Shadow copy of the per-level ready lists and the thread table.
  slot_t lvl_head  [NUM_LEVELS];
  slot_t lvl_tail  [NUM_LEVELS];
  logic  lvl_busy  [NUM_LEVELS];
  slot_t nxt       [NUM_SLOTS];
  logic  nxt_ok    [NUM_SLOTS];
  prio_t thr_prio  [NUM_SLOTS];
  logic  thr_ready [NUM_SLOTS];
  logic  thr_used  [NUM_SLOTS];

  // Results still owed by the block, oldest first.
  res_t  owed_results[$];
  res_t  want;
  res_t  got;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic prio_t clip_level(prio_t p);
    return (int'(p) >= NUM_LEVELS) ? prio_t'(NUM_LEVELS - 1) : p;
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < NUM_LEVELS; i++) begin
      lvl_head[i] = '0;
      lvl_tail[i] = '0;
      lvl_busy[i] = 1'b0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      nxt[i]       = '0;
      nxt_ok[i]    = 1'b0;
      thr_prio[i]  = '0;
      thr_ready[i] = 1'b0;
      thr_used[i]  = 1'b0;
    end
  endfunction

  // Append a thread at the tail of the level given by its priority.
  function automatic void queue_at_tail(slot_t s);
    prio_t lv;
    lv = thr_prio[s];
    nxt_ok[s] = 1'b0;
    nxt[s]    = '0;
    if (lvl_busy[lv]) begin
      nxt[lvl_tail[lv]]    = s;
      nxt_ok[lvl_tail[lv]] = 1'b1;
    end else begin
      lvl_head[lv] = s;
      lvl_busy[lv] = 1'b1;
    end
    lvl_tail[lv] = s;
    thr_ready[s] = 1'b1;
  endfunction

  // Remove a thread from wherever it sits in its level.
  function automatic void unlink_thread(slot_t s);
    prio_t lv;
    slot_t cur;
    slot_t prev;
    logic  has_prev;
    lv = thr_prio[s];
    if (lvl_busy[lv]) begin
      cur      = lvl_head[lv];
      prev     = '0;
      has_prev = 1'b0;
      for (int n = 0; n < NUM_SLOTS; n++) begin
        if (cur == s) begin
          if (!has_prev) begin
            if (nxt_ok[s]) lvl_head[lv] = nxt[s];
            else lvl_busy[lv] = 1'b0;
          end else begin
            nxt_ok[prev] = nxt_ok[s];
            nxt[prev]    = nxt[s];
            if (lvl_tail[lv] == s) lvl_tail[lv] = prev;
          end
          break;
        end
        if (!nxt_ok[cur]) break;
        prev     = cur;
        has_prev = 1'b1;
        cur      = nxt[cur];
      end
    end
    thr_ready[s] = 1'b0;
    nxt_ok[s]    = 1'b0;
    nxt[s]       = '0;
  endfunction

  // Apply one operation to the shadow tables and return its result.
  function automatic res_t apply_operation(in_item_t it);
    res_t  r;
    slot_t s;
    prio_t newp;
    logic  found;
    logic  in_range;
    r        = '0;
    s        = it.thread_slot;
    in_range = int'(s) < NUM_SLOTS;
    found    = 1'b0;
    case (it.opcode)
      OP_CREATE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && !thr_used[i]) begin
            found = 1'b1;
            s     = slot_t'(i);
          end
        end
        if (!found) begin
          r.status = ST_NONE;
        end else begin
          thr_used[s] = 1'b1;
          thr_prio[s] = clip_level(it.prio_value);
          queue_at_tail(s);
          r.chosen_slot = s;
        end
      end
      OP_SCHEDULE: begin
        r.status = ST_NONE;
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
          if (!found && lvl_busy[lv]) begin
            found         = 1'b1;
            r.status      = ST_OK;
            r.chosen_slot = lvl_head[lv];
          end
        end
      end
      OP_RELEASE: begin
        if (in_range && thr_used[s]) begin
          if (thr_ready[s]) unlink_thread(s);
          thr_used[s]  = 1'b0;
          thr_ready[s] = 1'b0;
          thr_prio[s]  = '0;
          nxt_ok[s]    = 1'b0;
          nxt[s]       = '0;
        end
      end
      OP_PUT: begin
        if (in_range && thr_used[s]) begin
          if (thr_ready[s]) r.status = ST_ALREADY;
          else queue_at_tail(s);
        end
      end
      OP_GET: begin
        if (in_range && thr_used[s]) begin
          if (!thr_ready[s]) r.status = ST_ALREADY;
          else unlink_thread(s);
        end
      end
      OP_CHPRIO: begin
        if (in_range && thr_used[s]) begin
          r.old_prio = thr_prio[s];
          newp       = (it.prio_value != '0) ? clip_level(it.prio_value) : thr_prio[s];
          if (thr_ready[s]) begin
            if (newp == thr_prio[s]) begin
              r.status = ST_ALREADY;
            end else begin
              unlink_thread(s);
              thr_prio[s] = newp;
              queue_at_tail(s);
            end
          end else begin
            thr_prio[s] = newp;
            queue_at_tail(s);
          end
        end
      end
      default: begin
        // Unused opcodes leave everything as it is.
      end
    endcase
    return r;
  endfunction

  initial begin
    errors      = 0;
    checked     = 0;
    outstanding = 0;
  end

  // Results are matched before new operations are predicted in the same cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tables();
      owed_results.delete();
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[$bits(res_t)-1:0]);
        checked++;
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with nothing owed", got));
        end else begin
          want = owed_results.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
          if (got.chosen_slot != want.chosen_slot)
            report_mismatch($sformatf("chosen_slot %0d, predicted %0d",
                                      got.chosen_slot, want.chosen_slot));
          if (got.old_prio != want.old_prio)
            report_mismatch($sformatf("old_prio %0d, predicted %0d",
                                      got.old_prio, want.old_prio));
        end
      end
      if (in_tvalid && in_tready)
        owed_results.push_back(apply_operation(in_item_t'(in_tdata[$bits(in_item_t)-1:0])));
      outstanding <= owed_results.size();
    end
  end

endmodule

// ----- tb/sv/priority_ready_queue_scheduler_test.sv -----
// Testbench top of the ready-queue scheduler: clock, reset, operation stimulus and verdict.
`timescale 1ns / 100ps

module priority_ready_queue_scheduler_test;
  import prqs_pkg::*;

  localparam int NUM_SLOTS   = 6;
  localparam int NUM_LEVELS  = 16;
  localparam int RANDOM_OPS  = 1830;
  localparam int HOLD_CYCLES = 70;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int errors;
  int checked;
  int outstanding;
  int sent;

  // Shared pacing flags: a long output hold, and stretches without any idling.
  bit hold_output;
  bit calm;
  bit no_gaps;

  priority_ready_queue_scheduler #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_LEVELS (NUM_LEVELS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  priority_ready_queue_scheduler_check #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_LEVELS (NUM_LEVELS)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .errors      (errors),
    .checked     (checked),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pause_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offer one operation and wait until the block takes it.
  task automatic send_op(logic [OPCODE_W-1:0] op, logic [SLOT_FIELD_W-1:0] slot,
                         logic [PRIO_FIELD_W-1:0] pv);
    in_item_t it;
    it.opcode      = op;
    it.thread_slot = slot;
    it.prio_value  = pv;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(it);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (!calm && !no_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (pause_len()) @(posedge clk);
    end
  endtask

  // Stop offering until every owed result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result side: mostly ready, random stalls, one long hold on request.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
      end
    end
  end

  // Random operation mix; most priorities fall in a few levels so lists grow long.
  task automatic send_random_op();
    logic [OPCODE_W-1:0]     op;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [PRIO_FIELD_W-1:0] pv;
    int                      pick;
    pick = $urandom_range(0, 99);
    if (pick < 16)      op = OP_CREATE;
    else if (pick < 32) op = OP_PUT;
    else if (pick < 48) op = OP_GET;
    else if (pick < 62) op = OP_SCHEDULE;
    else if (pick < 78) op = OP_CHPRIO;
    else if (pick < 95) op = OP_RELEASE;
    else                op = OP_RELEASE + OPCODE_W'($urandom_range(1, 2));
    if ($urandom_range(0, 9) == 0) slot = SLOT_FIELD_W'(NUM_SLOTS + $urandom_range(0, 1));
    else slot = SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1));
    if ($urandom_range(0, 9) < 7) pv = PRIO_FIELD_W'($urandom_range(0, 3));
    else pv = PRIO_FIELD_W'($urandom_range(0, 15));
    send_op(op, slot, pv);
  endtask

  initial begin
    sent        = 0;
    hold_output = 1'b0;
    calm        = 1'b0;
    no_gaps     = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases on a freshly reset table.
    send_op(OP_SCHEDULE, 3'd0, 4'd0);         // every level empty
    send_op(OP_PUT, 3'd2, 4'd0);              // slot never created
    send_op(OP_CREATE, 3'd7, 4'd0);
    send_op(OP_CREATE, 3'd0, 4'd5);
    send_op(OP_CREATE, 3'd0, 4'd5);
    send_op(OP_CREATE, 3'd0, 4'd5);
    send_op(OP_CREATE, 3'd0, 4'd15);
    send_op(OP_CREATE, 3'd0, 4'd15);
    send_op(OP_CREATE, 3'd0, 4'd9);           // table full
    send_op(OP_PUT, 3'd1, 4'd0);              // already ready
    send_op(OP_GET, 3'd2, 4'd0);              // middle of its level
    send_op(OP_GET, 3'd2, 4'd0);              // not ready any more
    send_op(OP_PUT, 3'd2, 4'd0);
    send_op(OP_CHPRIO, 3'd3, 4'd0);           // zero keeps the priority
    send_op(OP_CHPRIO, 3'd1, 4'd7);           // moves to another level
    send_op(OP_CHPRIO, 3'd2, 4'd5);           // same level while ready
    send_op(OP_GET, 3'd0, 4'd0);              // head of the top level
    send_op(OP_CHPRIO, 3'd0, 4'd12);          // not ready: requeued
    send_op(OP_RELEASE, 3'd4, 4'd0);          // ready slot is unlinked first
    send_op(OP_RELEASE, 3'd4, 4'd0);          // slot already free
    send_op(OP_GET, 3'd5, 4'd0);
    send_op(OP_RELEASE, 3'd5, 4'd0);          // not-ready slot
    send_op(OP_RELEASE + 3'd1, 3'd7, 4'd15);  // unused opcodes
    send_op(OP_RELEASE + 3'd2, 3'd6, 4'd0);
    send_op(OP_PUT, 3'd6, 4'd3);              // slots beyond the table
    send_op(OP_CHPRIO, 3'd7, 4'd3);
    drain();

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == 300) begin
        hold_output = 1'b1;
        no_gaps     = 1'b1;
      end
      if (i == 340) no_gaps = 1'b0;
      if (i == 700) drain();
      calm = (i >= 1000 && i < 1200);
      send_random_op();
    end

    drain();
    repeat (40) @(posedge clk);

    $display("Ran %0d operations: directed corner cases, then random mixes with stalls,",
             sent);
    $display("a long output hold and a full drain; %0d results compared, %0d mismatches.",
             checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Safety net in case the block stops answering.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
